// ===== rtl/core/ctr_pkg.sv =====
`timescale 1ns / 1ps

package ctr_pkg;

    localparam int MAX_CHUNKS = 64;
    localparam int SLOT_W     = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
    localparam int ID_W       = 32;
    localparam int SIZE_W     = 24;
    localparam int NUM_W      = 8;
    localparam int LEN_W      = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [SIZE_W-1:0] MAX_BYTES_RESET = 24'h100000;

    typedef enum logic [0:0] {
        REG_MAX_IMAGE_BYTES = 1'b0
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_NUM   = 3'd3,
        ST_BAD_SIZE  = 3'd4,
        ST_BEYOND    = 3'd5,
        ST_MISMATCH  = 3'd6
    } status_t;

endpackage

// ===== rtl/core/chunk_reassembly_tracker.sv =====
`timescale 1ns / 1ps

// Chunk reassembly tracker. Each input beat is one chunk header; each header
// produces exactly one result beat carrying a status code, the number of
// distinct chunks held and the byte total held. One header is accepted per
// clock cycle when the result side keeps up. The header and the read of the
// chunk length table are registered at acceptance, and the result register
// follows them and holds the result beat until it is taken.
// The table needs no clearing pass: a stored length is only used while its
// presence bit, held in flip-flops, is set.
// max_image_bytes sits at byte address 0 of the register port.

module chunk_reassembly_tracker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctr_pkg::ADDR_W-1:0]    paddr,
    input  logic [ctr_pkg::DATA_W-1:0]    pwdata,
    output logic [ctr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ctr_pkg::ID_W-1:0]      image_id,
    input  logic [ctr_pkg::SIZE_W-1:0]    image_size,
    input  logic [ctr_pkg::NUM_W-1:0]     chunk_number,
    input  logic [ctr_pkg::NUM_W-1:0]     chunk_count,
    input  logic [ctr_pkg::LEN_W-1:0]     chunk_len,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [ctr_pkg::CNT_W-1:0]     chunks_received,
    output logic [ctr_pkg::SIZE_W-1:0]    bytes_held
);

    import ctr_pkg::*;

    // configuration
    logic [SIZE_W-1:0] max_bytes_reg;
    logic              cfg_write;

    // input stage
    logic              s1_valid_reg;
    logic [ID_W-1:0]   s1_id_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    logic [NUM_W-1:0]  s1_num_reg;
    logic [NUM_W-1:0]  s1_cnt_reg;
    logic [LEN_W-1:0]  s1_len_reg;
    logic              s1_adv;
    logic              in_accept;

    // tracking state
    logic                  open_reg;
    logic                  open_next;
    logic [ID_W-1:0]       cur_id_reg;
    logic [ID_W-1:0]       cur_id_next;
    logic [CNT_W-1:0]      exp_cnt_reg;
    logic [CNT_W-1:0]      exp_cnt_next;
    logic [SIZE_W-1:0]     exp_bytes_reg;
    logic [SIZE_W-1:0]     exp_bytes_next;
    logic [CNT_W-1:0]      rc_reg;
    logic [CNT_W-1:0]      rc_next;
    logic [SIZE_W-1:0]     total_reg;
    logic [SIZE_W-1:0]     total_next;
    logic [MAX_CHUNKS-1:0] mask_reg;
    logic [MAX_CHUNKS-1:0] mask_next;

    // result register
    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic [CNT_W-1:0]  cnt_out_next;
    logic [SIZE_W-1:0] bytes_out_reg;
    logic [SIZE_W-1:0] bytes_out_next;

    // length table
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [LEN_W-1:0]  ram_rdata;
    logic [SLOT_W-1:0] rd_slot;
    logic              byp_reg;
    logic [LEN_W-1:0]  byp_data_reg;
    logic [LEN_W-1:0]  stored_len;
    logic              store_chunk;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        case (reg_index_t'(paddr[2]))
            REG_MAX_IMAGE_BYTES: prdata = {{(DATA_W - SIZE_W){1'b0}}, max_bytes_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (cfg_write && reg_index_t'(paddr[2]) == REG_MAX_IMAGE_BYTES)
        begin
            max_bytes_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_id_reg   <= image_id;
            s1_size_reg <= image_size;
            s1_num_reg  <= chunk_number;
            s1_cnt_reg  <= chunk_count;
            s1_len_reg  <= chunk_len;
        end
    end

    // table read issued as the header is taken in
    assign rd_slot = SLOT_W'(chunk_number - NUM_W'(1));

    ctr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_CHUNKS)
    ) u_len_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s1_len_reg),
        .re    (in_accept),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    // forward a write that lands on the slot being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            byp_reg <= ram_we && (ram_waddr == rd_slot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byp_data_reg <= s1_len_reg;
        end
    end

    assign stored_len = byp_reg ? byp_data_reg : ram_rdata;
    assign ram_waddr  = SLOT_W'(s1_num_reg - NUM_W'(1));
    assign ram_we     = s1_adv && store_chunk;

    always_comb
    begin
        logic              new_img;
        logic [CNT_W-1:0]  eff_cnt;
        logic [SIZE_W-1:0] eff_bytes;
        logic [CNT_W-1:0]  eff_rc;
        logic [SIZE_W-1:0] eff_total;
        logic [MAX_CHUNKS-1:0] eff_mask;
        logic              present;
        logic [SIZE_W-1:0] new_total;
        logic [CNT_W-1:0]  new_rc;

        new_img   = !open_reg || (s1_id_reg != cur_id_reg);
        eff_cnt   = new_img ? CNT_W'(s1_cnt_reg) : exp_cnt_reg;
        eff_bytes = new_img ? s1_size_reg : exp_bytes_reg;
        eff_rc    = new_img ? '0 : rc_reg;
        eff_total = new_img ? '0 : total_reg;
        eff_mask  = new_img ? '0 : mask_reg;
        present   = eff_mask[ram_waddr];
        new_total = eff_total - (present ? SIZE_W'(stored_len) : '0)
                    + SIZE_W'(s1_len_reg);
        new_rc    = eff_rc + CNT_W'(!present);

        store_chunk    = 1'b0;
        open_next      = 1'b0;
        cur_id_next    = '0;
        exp_cnt_next   = '0;
        exp_bytes_next = '0;
        rc_next        = '0;
        total_next     = '0;
        mask_next      = '0;
        status_next    = ST_ACCEPTED;
        cnt_out_next   = '0;
        bytes_out_next = '0;

        if (s1_len_reg == '0)
        begin
            status_next = ST_EMPTY;
        end
        else if (s1_cnt_reg == '0 || s1_cnt_reg > NUM_W'(MAX_CHUNKS)
                 || s1_num_reg == '0 || s1_num_reg > s1_cnt_reg)
        begin
            status_next = ST_BAD_NUM;
        end
        else if (s1_size_reg == '0 || s1_size_reg > max_bytes_reg)
        begin
            status_next = ST_BAD_SIZE;
        end
        else if (s1_num_reg > NUM_W'(eff_cnt))
        begin
            status_next = ST_BEYOND;
        end
        else
        begin
            store_chunk    = 1'b1;
            cnt_out_next   = new_rc;
            bytes_out_next = new_total;
            if (new_rc < eff_cnt)
            begin
                status_next    = ST_ACCEPTED;
                open_next      = 1'b1;
                cur_id_next    = s1_id_reg;
                exp_cnt_next   = eff_cnt;
                exp_bytes_next = eff_bytes;
                rc_next        = new_rc;
                total_next     = new_total;
                mask_next      = eff_mask;
                mask_next[ram_waddr] = 1'b1;
            end
            else if (new_total == eff_bytes)
            begin
                status_next = ST_COMPLETE;
            end
            else
            begin
                status_next = ST_MISMATCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            cur_id_reg    <= '0;
            exp_cnt_reg   <= '0;
            exp_bytes_reg <= '0;
            rc_reg        <= '0;
            total_reg     <= '0;
            mask_reg      <= '0;
        end
        else if (s1_adv)
        begin
            open_reg      <= open_next;
            cur_id_reg    <= cur_id_next;
            exp_cnt_reg   <= exp_cnt_next;
            exp_bytes_reg <= exp_bytes_next;
            rc_reg        <= rc_next;
            total_reg     <= total_next;
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg    <= status_next;
            cnt_out_reg   <= cnt_out_next;
            bytes_out_reg <= bytes_out_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign chunks_received = cnt_out_reg;
    assign bytes_held      = bytes_out_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_BAD_NUM
                      || status == ST_BAD_SIZE || status == ST_BEYOND)
        |-> chunks_received == '0 && bytes_held == '0)
        else $error("rejected beat carries nonzero counts");

    a_count_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg == CNT_W'($countones(mask_reg)))
        else $error("received count disagrees with presence mask");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> rc_reg < exp_cnt_reg && rc_reg != '0)
        else $error("open image count out of range");

    a_closed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> rc_reg == '0 && total_reg == '0 && mask_reg == '0)
        else $error("closed image left state behind");

    a_accept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ACCEPTED |-> chunks_received != '0)
        else $error("accepted beat with no chunks held");

endmodule

// ===== rtl/core/ctr_ram.sv =====
`timescale 1ns / 1ps

module ctr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sim/chunk_checker.sv =====
`timescale 1ns / 1ps

module chunk_checker (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ctr_pkg::ADDR_W-1:0]    paddr,
    input  logic [ctr_pkg::DATA_W-1:0]    pwdata,

    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [ctr_pkg::ID_W-1:0]      image_id,
    input  logic [ctr_pkg::SIZE_W-1:0]    image_size,
    input  logic [ctr_pkg::NUM_W-1:0]     chunk_number,
    input  logic [ctr_pkg::NUM_W-1:0]     chunk_count,
    input  logic [ctr_pkg::LEN_W-1:0]     chunk_len,

    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [2:0]                    status,
    input  logic [ctr_pkg::CNT_W-1:0]     chunks_received,
    input  logic [ctr_pkg::SIZE_W-1:0]    bytes_held,

    output int                            errors,
    output int                            outstanding
);

    import ctr_pkg::*;

    typedef struct packed {
        status_t             code;
        logic [CNT_W-1:0]    held;
        logic [SIZE_W-1:0]   bytes;
    } tally_t;

    logic [SIZE_W-1:0]  size_cap;
    bit                 open;
    logic [ID_W-1:0]    open_id;
    logic [CNT_W-1:0]   want_chunks;
    logic [CNT_W-1:0]   got_chunks;
    logic [SIZE_W-1:0]  want_bytes;
    logic [SIZE_W-1:0]  held_bytes;
    logic [MAX_CHUNKS-1:0] present;
    logic [LEN_W-1:0]   slot_len [MAX_CHUNKS];
    tally_t             due_q [$];

    function automatic void close_image();
        open = 1'b0;
        open_id = '0;
        want_chunks = '0;
        want_bytes = '0;
        got_chunks = '0;
        held_bytes = '0;
        present = '0;
    endfunction

    function automatic tally_t file_chunk(
        input logic [ID_W-1:0]   id,
        input logic [SIZE_W-1:0] sz,
        input logic [NUM_W-1:0]  num,
        input logic [NUM_W-1:0]  cnt,
        input logic [LEN_W-1:0]  len
    );
        tally_t t;
        int slot;
        t = '{code: ST_ACCEPTED, held: '0, bytes: '0};
        if (len == 0)
        begin
            t.code = ST_EMPTY;
        end
        else if (cnt == 0 || cnt > MAX_CHUNKS || num == 0 || num > cnt)
        begin
            t.code = ST_BAD_NUM;
        end
        else if (sz == 0 || sz > size_cap)
        begin
            t.code = ST_BAD_SIZE;
        end
        else
        begin
            if (!open || id != open_id)
            begin
                close_image();
                open = 1'b1;
                open_id = id;
                want_chunks = CNT_W'(cnt);
                want_bytes = sz;
            end
            if (num > want_chunks)
            begin
                t.code = ST_BEYOND;
            end
            else
            begin
                slot = int'(num) - 1;
                if (present[slot])
                begin
                    held_bytes = held_bytes - SIZE_W'(slot_len[slot]);
                end
                else
                begin
                    present[slot] = 1'b1;
                    got_chunks = got_chunks + 1'b1;
                end
                slot_len[slot] = len;
                held_bytes = held_bytes + SIZE_W'(len);
                t.held = got_chunks;
                t.bytes = held_bytes;
                if (got_chunks == want_chunks)
                begin
                    if (held_bytes == want_bytes)
                        t.code = ST_COMPLETE;
                    else
                        t.code = ST_MISMATCH;
                end
            end
        end
        if (t.code != ST_ACCEPTED)
            close_image();
        return t;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        if (errors < 100)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tally_t want;
        if (!rst_n)
        begin
            size_cap = MAX_BYTES_RESET;
            close_image();
            due_q.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {REG_MAX_IMAGE_BYTES, 2'b00})
                size_cap = pwdata[SIZE_W-1:0];

            if (out_valid && out_ready)
            begin
                if (due_q.size() == 0)
                begin
                    report("unexpected result beat, status", status, 0);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (status != want.code)
                        report("status", status, want.code);
                    if (chunks_received != want.held)
                        report("chunks_received", chunks_received, want.held);
                    if (bytes_held != want.bytes)
                        report("bytes_held", bytes_held, want.bytes);
                end
            end

            if (in_valid && in_ready)
                due_q.push_back(file_chunk(image_id, image_size, chunk_number,
                                           chunk_count, chunk_len));

            outstanding <= due_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import ctr_pkg::*;

    localparam int IDLE_LIMIT = 1000;

    logic                 clk;
    logic                 rst_n = 1'b0;

    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ID_W-1:0]      image_id = '0;
    logic [SIZE_W-1:0]    image_size = '0;
    logic [NUM_W-1:0]     chunk_number = '0;
    logic [NUM_W-1:0]     chunk_count = '0;
    logic [LEN_W-1:0]     chunk_len = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           status;
    logic [CNT_W-1:0]     chunks_received;
    logic [SIZE_W-1:0]    bytes_held;

    int                   errors;
    int                   outstanding;
    bit                   steady = 1'b0;
    int                   sent = 0;
    int                   rx_hold = 0;
    int                   quiet = 0;

    chunk_reassembly_tracker dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .image_id        (image_id),
        .image_size      (image_size),
        .chunk_number    (chunk_number),
        .chunk_count     (chunk_count),
        .chunk_len       (chunk_len),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chunks_received (chunks_received),
        .bytes_held      (bytes_held)
    );

    chunk_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .image_id        (image_id),
        .image_size      (image_size),
        .chunk_number    (chunk_number),
        .chunk_count     (chunk_count),
        .chunk_len       (chunk_len),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .chunks_received (chunks_received),
        .bytes_held      (bytes_held),
        .errors          (errors),
        .outstanding     (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin : rx_side
        int w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (out_ready)
        begin
            if (out_valid)
            begin
                w = steady ? 0 : $urandom_range(0, 6);
                if (w != 0)
                begin
                    out_ready <= 1'b0;
                    rx_hold <= w;
                end
            end
        end
        else if (rx_hold > 1)
        begin
            rx_hold <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic push_chunk(
        input logic [ID_W-1:0]   id,
        input logic [SIZE_W-1:0] sz,
        input logic [NUM_W-1:0]  num,
        input logic [NUM_W-1:0]  cnt,
        input logic [LEN_W-1:0]  len
    );
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        image_id <= id;
        image_size <= sz;
        chunk_number <= num;
        chunk_count <= cnt;
        chunk_len <= len;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // drain every pending beat before touching the register
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic send_image();
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] img_size;
        logic [LEN_W-1:0]  lens [MAX_CHUNKS];
        int                order [MAX_CHUNKS];
        int                cnt, n, j, k, t, stop, byte_sum;
        id = $urandom;
        case ($urandom_range(0, 15))
            0:       cnt = MAX_CHUNKS;
            1, 2:    cnt = $urandom_range(9, MAX_CHUNKS - 1);
            default: cnt = $urandom_range(1, 8);
        endcase
        byte_sum = 0;
        for (k = 0; k < cnt; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                lens[k] = LEN_W'($urandom_range(1, 65535));
            else
                lens[k] = LEN_W'($urandom_range(1, 300));
            byte_sum += lens[k];
            order[k] = k + 1;
        end
        if ($urandom_range(0, 4) == 0)
            img_size = SIZE_W'($urandom_range(1, byte_sum + 3));
        else
            img_size = SIZE_W'(byte_sum);
        for (k = cnt - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cnt) : cnt;
        for (k = 0; k < stop; k++)
        begin
            n = order[k];
            t = ($urandom_range(0, 5) == 0) ? $urandom_range(n, MAX_CHUNKS) : cnt;
            push_chunk(id, img_size, NUM_W'(n), NUM_W'(t), lens[n-1]);
            if (k + 1 < cnt && $urandom_range(0, 19) == 0)
            begin
                j = order[$urandom_range(0, k)];
                if ($urandom_range(0, 1) == 1)
                    lens[j-1] = LEN_W'($urandom_range(1, 65535));
                push_chunk(id, img_size, NUM_W'(j), NUM_W'(cnt), lens[j-1]);
            end
        end
        if (stop < cnt && cnt < MAX_CHUNKS && $urandom_range(0, 1) == 1)
            push_chunk(id, img_size, NUM_W'($urandom_range(cnt + 1, MAX_CHUNKS)),
                       NUM_W'(MAX_CHUNKS), LEN_W'($urandom_range(1, 65535)));
    endtask

    initial
    begin
        int ph;
        int base;
        logic [SIZE_W-1:0] cap;
        logic [NUM_W-1:0] num_f;
        logic [NUM_W-1:0] cnt_f;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_chunk(32'h0, 24'd100, 8'd1, 8'd1, 16'd0);
        push_chunk(32'h0, 24'd100, 8'd1, 8'd0, 16'd10);
        push_chunk(32'h0, 24'd100, 8'd1, 8'd65, 16'd10);
        push_chunk(32'h0, 24'd100, 8'd0, 8'd4, 16'd10);
        push_chunk(32'h0, 24'd100, 8'd255, 8'd255, 16'd10);
        push_chunk(32'h0, 24'd100, 8'd5, 8'd4, 16'd10);
        push_chunk(32'h0, 24'd0, 8'd1, 8'd1, 16'd10);
        push_chunk(32'h0, MAX_BYTES_RESET + 1'b1, 8'd1, 8'd1, 16'd10);
        push_chunk(32'hFFFF_FFFF, MAX_BYTES_RESET, 8'd1, 8'd3, 16'hFFFF);
        push_chunk(32'hFFFF_FFFF, MAX_BYTES_RESET, 8'd1, 8'd3, 16'd100);
        push_chunk(32'hFFFF_FFFF, MAX_BYTES_RESET, 8'd10, 8'd64, 16'd100);
        push_chunk(32'h1234_5678, 24'd300, 8'd2, 8'd2, 16'd200);
        push_chunk(32'h1234_5678, 24'd300, 8'd1, 8'd8, 16'd100);
        push_chunk(32'h0, 24'd65535, 8'd1, 8'd1, 16'hFFFF);
        push_chunk(32'h1, 24'd6, 8'd1, 8'd1, 16'd5);
        push_chunk(32'hA5A5_A5A5, 24'd500, 8'd1, 8'd3, 16'd50);
        push_chunk(32'h5A5A_5A5A, 24'd30, 8'd1, 8'd2, 16'd10);
        push_chunk(32'h5A5A_5A5A, 24'd30, 8'd2, 8'd2, 16'd20);
        push_chunk(32'h77, 24'd4000, 8'd64, 8'd64, 16'd1000);
        push_chunk(32'h77, 24'd4000, 8'd64, 8'd64, 16'd0);

        settle();
        write_reg(REG_MAX_IMAGE_BYTES, 32'd1);
        push_chunk(32'h9, 24'd1, 8'd1, 8'd1, 16'd1);
        push_chunk(32'h9, 24'd2, 8'd1, 8'd1, 16'd1);
        push_chunk(32'hA, 24'd1, 8'd1, 8'd2, 16'd1);
        push_chunk(32'hA, 24'd1, 8'd2, 8'd2, 16'd1);

        base = sent;
        for (ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:       cap = 24'hFF_FFFF;
                1:       cap = SIZE_W'($urandom_range(2000, 24'hFF_FFFF));
                2:       cap = MAX_BYTES_RESET;
                default: cap = SIZE_W'($urandom_range(1000, 200000));
            endcase
            write_reg(REG_MAX_IMAGE_BYTES, DATA_W'(cap));
            if (ph == 0)
                push_chunk(32'hC3C3_3C3C, 24'hFF_FFFF, 8'd1, 8'd1, 16'hFFFF);
            while (sent < base + 100 * (ph + 1))
            begin
                steady = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) < 8)
                begin
                    send_image();
                end
                else
                begin
                    cnt_f = ($urandom_range(0, 1) == 1) ? NUM_W'($urandom)
                                                         : NUM_W'($urandom_range(1, 64));
                    num_f = ($urandom_range(0, 1) == 1) ? NUM_W'($urandom)
                                                         : NUM_W'($urandom_range(1, 64));
                    push_chunk($urandom, SIZE_W'($urandom), num_f, cnt_f,
                               ($urandom_range(0, 2) == 0) ? '0 : LEN_W'($urandom));
                end
            end
        end

        steady = 1'b0;
        settle();
        if (errors == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
